// File: rtl/address_range_map_assert.svh
// Assertion shorthands shared by the range map modules.
// Both sample on clk and stay quiet while rst is high.
`ifndef ADDRESS_RANGE_MAP_ASSERT_SVH
`define ADDRESS_RANGE_MAP_ASSERT_SVH

// Same-cycle implication.
`define ARM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ARM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/arm_pkg.sv
package arm_pkg;

  localparam int ENTRIES   = 256;
  localparam int ADDR_BITS = 64;
  localparam int TAG_BITS  = 32;

  localparam int CNT_W   = $clog2(ENTRIES);
  localparam int COUNT_W = $clog2(ENTRIES + 1);

  // input word layout, lowest bits first: low_bound, high_bound, entry_tag, probe_addr
  localparam int OFF_LO    = 0;
  localparam int OFF_HI    = ADDR_BITS;
  localparam int OFF_TAG   = 2 * ADDR_BITS;
  localparam int OFF_PROBE = 2 * ADDR_BITS + TAG_BITS;
  localparam int IN_W       = 3 * ADDR_BITS + TAG_BITS;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

  // output word layout, lowest bits first: status, hit, tag_out
  localparam int OUT_W       = 3 + TAG_BITS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_CLOSE  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERLAP  = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_BADRANGE = 2'd3;

  // upper bound given to the highest range by a close: all ones minus one
  localparam logic [ADDR_BITS-1:0] TOP_HIGH = {{(ADDR_BITS - 1){1'b1}}, 1'b0};

  typedef struct packed {
    logic                 start;
    logic                 run;
    logic                 ins_wr;
    logic                 close_wr;
    logic                 clear;
    logic [ADDR_BITS-1:0] lo;
    logic [ADDR_BITS-1:0] hi;
    logic [ADDR_BITS-1:0] probe;
    logic [TAG_BITS-1:0]  tag;
  } cell_cmd_t;

  // result token walking down the chain
  typedef struct packed {
    logic                found;
    logic                ovl;
    logic [TAG_BITS-1:0] tag;
  } tok_t;

  // lower bound circulating around the ring during a close
  typedef struct packed {
    logic                 v;
    logic [ADDR_BITS-1:0] low;
  } circ_t;

endpackage

// File: rtl/arm_cell.sv
`include "address_range_map_assert.svh"

module arm_cell (
  input  logic              clk,
  input  logic              rst,
  input  arm_pkg::cell_cmd_t cmd,
  input  logic              prev_valid,
  input  arm_pkg::tok_t     tok_in,
  input  arm_pkg::circ_t    circ_in,
  output logic              valid,
  output arm_pkg::tok_t     tok_out,
  output arm_pkg::circ_t    circ_out
);

  logic [arm_pkg::ADDR_BITS-1:0] low;
  logic [arm_pkg::ADDR_BITS-1:0] high;
  logic [arm_pkg::TAG_BITS-1:0]  tag;
  logic [arm_pkg::ADDR_BITS-1:0] best;
  logic                          best_f;
  arm_pkg::circ_t                circ;
  arm_pkg::tok_t                 tok;

  logic my_hit;
  logic my_ovl;
  logic c_take;

  assign my_hit = valid && (cmd.probe >= low) && (cmd.probe <= high);
  assign my_ovl = valid && !((cmd.hi <= low) || (cmd.lo >= high));
  assign c_take = circ.v && (circ.low > low) && (!best_f || (circ.low < best));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.ins_wr && !valid && prev_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    // the first empty cell behind a full one takes the new range
    if (cmd.ins_wr && !valid && prev_valid) begin
      low  <= cmd.lo;
      high <= cmd.hi;
      tag  <= cmd.tag;
    end else if (cmd.close_wr && valid) begin
      high <= best_f ? (best - arm_pkg::ADDR_BITS'(1)) : arm_pkg::TOP_HIGH;
    end

    // pass the token one cell on; the earliest hit keeps its tag
    tok.found <= tok_in.found | my_hit;
    tok.ovl   <= tok_in.ovl | my_ovl;
    tok.tag   <= tok_in.found ? tok_in.tag : (my_hit ? tag : '0);

    // rotate the lower bounds and keep the smallest one above our own
    if (cmd.start) begin
      circ.v   <= valid;
      circ.low <= low;
      best_f   <= 1'b0;
    end else begin
      circ <= circ_in;
      if (cmd.run && c_take) begin
        best   <= circ.low;
        best_f <= 1'b1;
      end
    end
  end

  assign tok_out  = tok;
  assign circ_out = circ;

  `ARM_ASSERT_NOW(a_valid_prefix, !prev_valid, !valid, "valid cell behind an empty cell")
  `ARM_ASSERT_NEXT(a_clear_empties, cmd.clear, !valid, "cell still valid after clear")

endmodule

// File: rtl/arm_ctrl.sv
`include "address_range_map_assert.svh"

module arm_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [arm_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [arm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  arm_pkg::tok_t                   tok_last,
  input  logic                            last_valid,
  output arm_pkg::cell_cmd_t              cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state;
  logic [arm_pkg::CNT_W-1:0]       cnt;
  logic [arm_pkg::COUNT_W-1:0]     count;
  logic [1:0]                      func;
  logic [arm_pkg::ADDR_BITS-1:0]   lo;
  logic [arm_pkg::ADDR_BITS-1:0]   hi;
  logic [arm_pkg::ADDR_BITS-1:0]   probe;
  logic [arm_pkg::TAG_BITS-1:0]    tag;

  logic                            accept;
  logic                            fire;
  logic [1:0]                      status;
  logic                            hit;
  logic [arm_pkg::OUT_TDATA_W-1:0] m_data_next;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fire     = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    status = arm_pkg::STAT_OK;
    if (func == arm_pkg::FUNC_INSERT) begin
      priority if (lo > hi) begin
        status = arm_pkg::STAT_BADRANGE;
      end else if (count >= arm_pkg::COUNT_W'(arm_pkg::ENTRIES)) begin
        status = arm_pkg::STAT_FULL;
      end else if (tok_last.ovl) begin
        status = arm_pkg::STAT_OVERLAP;
      end else begin
        status = arm_pkg::STAT_OK;
      end
    end
  end

  assign hit = (func == arm_pkg::FUNC_LOOKUP) && tok_last.found;

  always_comb begin
    m_data_next = '0;
    m_data_next[1:0] = status;
    m_data_next[2]   = hit;
    m_data_next[arm_pkg::OUT_W-1:3] = hit ? tok_last.tag : '0;
  end

  always_comb begin
    cmd.start    = accept;
    cmd.run      = (state == ST_RUN);
    cmd.ins_wr   = fire && (func == arm_pkg::FUNC_INSERT) && (status == arm_pkg::STAT_OK);
    cmd.close_wr = fire && (func == arm_pkg::FUNC_CLOSE);
    cmd.clear    = fire && (func == arm_pkg::FUNC_CLEAR);
    cmd.lo       = lo;
    cmd.hi       = hi;
    cmd.probe    = probe;
    cmd.tag      = tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          // one step per cell so the token reaches the chain end
          if (cnt == arm_pkg::CNT_W'(arm_pkg::ENTRIES - 1)) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt + arm_pkg::CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.ins_wr) begin
        count <= count + arm_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func  <= s_tuser;
      lo    <= s_tdata[arm_pkg::OFF_LO +: arm_pkg::ADDR_BITS];
      hi    <= s_tdata[arm_pkg::OFF_HI +: arm_pkg::ADDR_BITS];
      tag   <= s_tdata[arm_pkg::OFF_TAG +: arm_pkg::TAG_BITS];
      probe <= s_tdata[arm_pkg::OFF_PROBE +: arm_pkg::ADDR_BITS];
    end
    if (fire) begin
      m_tdata <= m_data_next;
    end
  end

  `ARM_ASSERT_NOW(a_count_tracks_cells, 1'b1, (count == arm_pkg::COUNT_W'(arm_pkg::ENTRIES)) == last_valid, "fill count disagrees with cell chain")
  `ARM_ASSERT_NEXT(a_accept_starts_walk, accept, (state == ST_RUN) && (cnt == '0), "accepted word did not start a chain walk")
  `ARM_ASSERT_NOW(a_result_from_done, $rose(m_tvalid), $past(state) == ST_DONE, "result raised outside the commit step")
  `ARM_ASSERT_NEXT(a_refused_keeps_count, fire && (func == arm_pkg::FUNC_INSERT) && (status != arm_pkg::STAT_OK), $stable(count), "refused insert changed the fill count")

endmodule

// File: rtl/address_range_map.sv
// Address range map: a chain of ENTRIES range cells, filled in insertion order,
// that inserts a range with a tag (refused when low is above high, when full, or
// when it overlaps a stored range), looks up the earliest-inserted range holding
// a probe address, closes every upper bound up to just below the next higher
// lower bound (the highest one up to all ones minus one), or clears the table.
// For each input word one result token walks the cell chain one cell per cycle
// while the stored lower bounds rotate once around the ring for a close, followed
// by a commit step that waits while the output register holds an untaken
// result, and the next word is taken while the new result waits in that register.
module address_range_map (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // low_bound, high_bound, entry_tag, probe_addr
  input  logic [arm_pkg::IN_TDATA_W-1:0]  s_tdata,
  // func
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status, hit, tag_out, zero fill
  output logic [arm_pkg::OUT_TDATA_W-1:0] m_tdata
);

  arm_pkg::cell_cmd_t cmd;
  arm_pkg::tok_t      tok  [arm_pkg::ENTRIES];
  arm_pkg::circ_t     circ [arm_pkg::ENTRIES];
  logic               vld  [arm_pkg::ENTRIES];

  arm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .tok_last   (tok[arm_pkg::ENTRIES-1]),
    .last_valid (vld[arm_pkg::ENTRIES-1]),
    .cmd        (cmd)
  );

  for (genvar i = 0; i < arm_pkg::ENTRIES; i++) begin : g_cell
    arm_pkg::tok_t tok_in;
    logic          prev_valid;

    if (i == 0) begin : g_head
      assign tok_in     = '0;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign tok_in     = tok[i-1];
      assign prev_valid = vld[i-1];
    end

    arm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev_valid (prev_valid),
      .tok_in     (tok_in),
      .circ_in    (circ[(i + arm_pkg::ENTRIES - 1) % arm_pkg::ENTRIES]),
      .valid      (vld[i]),
      .tok_out    (tok[i]),
      .circ_out   (circ[i])
    );
  end

endmodule
